// ===== hw/rtl/fng_pkg.sv =====
// ----------------------------------------------------------------------------
// fng_pkg
// Shared types and constants of the feature gallery distance block.
// ----------------------------------------------------------------------------
package fng_pkg;

    // sizes of the stores
    localparam int MAX_TRACKS    = 32;
    localparam int GALLERY_DEPTH = 16;
    localparam int FEATURE_DIM   = 256;
    localparam int ELEMENT_WIDTH = 16;

    localparam int SLOT_W = 5;
    localparam int ROW_W  = $clog2(GALLERY_DEPTH);
    localparam int POS_W  = $clog2(FEATURE_DIM);
    localparam int IDX_W  = POS_W + 1;
    localparam int CNT_W  = ROW_W + 1;
    localparam int ADDR_W = SLOT_W + ROW_W + POS_W;

    // arithmetic widths
    localparam int ACC_W     = 2 * ELEMENT_WIDTH + POS_W;
    localparam int PROD_W    = 2 * ACC_W;
    localparam int ROOT_W    = ACC_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int QUO_BITS  = 25;
    localparam int DIST_W    = 48;
    localparam int ITER_W    = 6;
    localparam int BUDGET_W  = 5;

    localparam logic [DIST_W-1:0] ONE_Q24  = DIST_W'(1) << 24;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // item queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // configuration register indexes
    localparam logic REG_METRIC = 1'b0;
    localparam logic REG_BUDGET = 1'b1;

    typedef enum logic [1:0] {
        CMD_APPEND,
        CMD_QUERY,
        CMD_MARK,
        CMD_PRUNE
    } fng_cmd_t;

    // classified item handed from front to back
    typedef struct packed {
        fng_cmd_t                 cmd;
        logic [SLOT_W-1:0]        slot;
        logic                     slot_ok;
        logic [ELEMENT_WIDTH-1:0] elem;
        logic [POS_W-1:0]         pos;
        logic                     in_range;
        logic                     last;
        logic                     full;
        logic [IDX_W-1:0]         qlen;
    } fng_op_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SCAN,
        B_EVAL,
        B_MUL,
        B_SQRT,
        B_QSET,
        B_DIV,
        B_QEND,
        B_NEXT,
        B_RESULT
    } fng_state_t;

endpackage

// ===== hw/rtl/feature_gallery_nn_distance.sv =====
// ----------------------------------------------------------------------------
// feature_gallery_nn_distance
// Per-track feature galleries with nearest-neighbour distance queries.
// ----------------------------------------------------------------------------
// Items enter a front stage that tracks the element position and feeds a
// four-entry queue; the back end executes them. Appends, query elements,
// marks and prunes are carried out by the back end as it takes them. The
// last element of a query walks the track's stored vectors through one
// gallery read port, one element per cycle within each vector. Squared
// euclidean distance and a zero cosine norm need only the accumulated sums;
// for cosine distance a shift add multiplier, a bit-serial square root and a
// restoring divider run in turn, and the divider is skipped when the cosine
// magnitude reaches one. The result register is loaded once the previous
// result has been taken. The gallery needs no clearing after reset, since a
// track's count bounds reads.
// ----------------------------------------------------------------------------
module feature_gallery_nn_distance
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         command,
    input  logic [fng_pkg::SLOT_W-1:0]         track_slot,
    input  logic signed [fng_pkg::ELEMENT_WIDTH-1:0] feature_element,
    input  logic                               last_element,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [fng_pkg::DIST_W-1:0]         nn_distance,
    output logic                               gallery_empty,
    output logic                               zero_norm,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [fng_pkg::BUDGET_W-1:0]       cfg_data
);

    logic                          metric_reg;
    logic [fng_pkg::BUDGET_W-1:0]  budget_reg;
    logic                          push_valid, push_ready;
    logic                          pop_valid, pop_ready;
    fng_pkg::fng_op_t              push_op, pop_op;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= 1'b0;
            budget_reg <= fng_pkg::BUDGET_W'(fng_pkg::GALLERY_DEPTH);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fng_pkg::REG_METRIC: metric_reg <= cfg_data[0];
                fng_pkg::REG_BUDGET: budget_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    fng_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .track_slot      (track_slot),
        .feature_element (feature_element),
        .last_element    (last_element),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_op         (push_op)
    );

    fng_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    fng_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .op_valid      (pop_valid),
        .op_ready      (pop_ready),
        .op            (pop_op),
        .metric        (metric_reg),
        .budget        (budget_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .nn_distance   (nn_distance),
        .gallery_empty (gallery_empty),
        .zero_norm     (zero_norm)
    );

endmodule

// ===== hw/rtl/fng_front.sv =====
// ----------------------------------------------------------------------------
// fng_front
// Accepts items, tracks the shared element position and classifies each item.
// ----------------------------------------------------------------------------
module fng_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         command,
    input  logic [fng_pkg::SLOT_W-1:0]         track_slot,
    input  logic signed [fng_pkg::ELEMENT_WIDTH-1:0] feature_element,
    input  logic                               last_element,
    output logic                               push_valid,
    input  logic                               push_ready,
    output fng_pkg::fng_op_t                   push_op
);

    logic [fng_pkg::IDX_W-1:0] elem_idx_reg;
    logic [fng_pkg::IDX_W-1:0] elem_idx_next;
    logic [fng_pkg::IDX_W-1:0] pos_inc;
    logic                      in_range;
    logic                      accept;
    fng_pkg::fng_cmd_t         cmd;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;
    assign cmd        = fng_pkg::fng_cmd_t'(command);

    // element position classification
    assign in_range = elem_idx_reg < fng_pkg::IDX_W'(fng_pkg::FEATURE_DIM);
    assign pos_inc  = in_range ? elem_idx_reg + fng_pkg::IDX_W'(1) : elem_idx_reg;

    always_comb
    begin
        push_op.cmd      = cmd;
        push_op.slot     = track_slot;
        push_op.slot_ok  = {1'b0, track_slot} < (fng_pkg::SLOT_W + 1)'(fng_pkg::MAX_TRACKS);
        push_op.elem     = feature_element;
        push_op.pos      = elem_idx_reg[fng_pkg::POS_W-1:0];
        push_op.in_range = in_range;
        push_op.last     = last_element;
        push_op.full     = elem_idx_reg == fng_pkg::IDX_W'(fng_pkg::FEATURE_DIM - 1);
        push_op.qlen     = pos_inc;
    end

    // next position, shared by appends and queries
    always_comb
    begin
        elem_idx_next = elem_idx_reg;
        if (accept && (cmd == fng_pkg::CMD_APPEND || cmd == fng_pkg::CMD_QUERY))
        begin
            elem_idx_next = last_element ? '0 : pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_idx_reg <= '0;
        end
        else
        begin
            elem_idx_reg <= elem_idx_next;
        end
    end

endmodule

// ===== hw/rtl/fng_queue.sv =====
// ----------------------------------------------------------------------------
// fng_queue
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module fng_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  fng_pkg::fng_op_t push_op,
    output logic             pop_valid,
    input  logic             pop_ready,
    output fng_pkg::fng_op_t pop_op
);

    fng_pkg::fng_op_t              slot_q [fng_pkg::QUEUE_DEPTH];
    logic [fng_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [fng_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [fng_pkg::QPTR_W:0]      count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = count_reg != (fng_pkg::QPTR_W + 1)'(fng_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_op     = slot_q[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_q[wr_ptr_reg] <= push_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + fng_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + fng_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (fng_pkg::QPTR_W + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (fng_pkg::QPTR_W + 1)'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/fng_back.sv =====
// ----------------------------------------------------------------------------
// fng_back
// Carries out items: gallery writes, track bookkeeping and the distance search.
// ----------------------------------------------------------------------------
module fng_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              op_valid,
    output logic                              op_ready,
    input  fng_pkg::fng_op_t                  op,
    input  logic                              metric,
    input  logic [fng_pkg::BUDGET_W-1:0]      budget,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fng_pkg::DIST_W-1:0]        nn_distance,
    output logic                              gallery_empty,
    output logic                              zero_norm
);

    localparam int AW = fng_pkg::ACC_W;

    // memories
    logic [fng_pkg::ELEMENT_WIDTH-1:0] gal_mem [fng_pkg::MAX_TRACKS * fng_pkg::GALLERY_DEPTH
                                                * fng_pkg::FEATURE_DIM];
    logic [fng_pkg::ELEMENT_WIDTH-1:0] qb_mem [fng_pkg::FEATURE_DIM];
    logic [fng_pkg::ELEMENT_WIDTH-1:0] gal_rdata;
    logic [fng_pkg::ELEMENT_WIDTH-1:0] qb_rdata;
    logic                              gal_we;
    logic                              qb_we;
    logic [fng_pkg::ADDR_W-1:0]        gal_waddr;
    logic [fng_pkg::ADDR_W-1:0]        gal_raddr;

    // per-track bookkeeping
    logic [fng_pkg::CNT_W-1:0]  cnt_reg  [fng_pkg::MAX_TRACKS];
    logic [fng_pkg::CNT_W-1:0]  cnt_next [fng_pkg::MAX_TRACKS];
    logic [fng_pkg::ROW_W-1:0]  old_reg  [fng_pkg::MAX_TRACKS];
    logic [fng_pkg::ROW_W-1:0]  old_next [fng_pkg::MAX_TRACKS];
    logic [fng_pkg::MAX_TRACKS-1:0] mark_reg;
    logic [fng_pkg::MAX_TRACKS-1:0] mark_next;

    // control
    fng_pkg::fng_state_t state_reg, state_next;
    logic [fng_pkg::SLOT_W-1:0] q_slot_reg, q_slot_next;
    logic [fng_pkg::IDX_W-1:0]  q_len_reg, q_len_next;
    logic [fng_pkg::CNT_W-1:0]  q_cnt_reg, q_cnt_next;
    logic [fng_pkg::ROW_W-1:0]  q_old_reg, q_old_next;
    logic [fng_pkg::CNT_W-1:0]  k_reg, k_next;
    logic [fng_pkg::IDX_W-1:0]  j_reg, j_next;
    logic [fng_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic                       v1_reg, v2_reg;
    logic                       issue;
    logic                       empty_reg, empty_next;
    logic                       zflag_reg, zflag_next;

    // datapath
    logic signed [fng_pkg::ELEMENT_WIDTH:0]       diff;
    logic signed [2*fng_pkg::ELEMENT_WIDTH+1:0]   sq_w;
    logic signed [2*fng_pkg::ELEMENT_WIDTH-1:0]   aa_w, ab_w, bb_w;
    logic [2*fng_pkg::ELEMENT_WIDTH+1:0]          sq_reg;
    logic [2*fng_pkg::ELEMENT_WIDTH-1:0]          aa_reg, ab_reg, bb_reg;
    logic [AW-1:0] acc_d_reg, acc_d_next;
    logic [AW-1:0] acc_ng_reg, acc_ng_next;
    logic [AW-1:0] acc_nq_reg, acc_nq_next;
    logic [AW-1:0] acc_dot_reg, acc_dot_next;
    logic [fng_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [fng_pkg::PROD_W-1:0] mcand_reg, mcand_next;
    logic [AW-1:0]              mlt_reg, mlt_next;
    logic [fng_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [fng_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [fng_pkg::REM_W-1:0]  rem_t, trial;
    logic [AW:0]                r_reg, r_next, r2;
    logic [fng_pkg::QUO_BITS-1:0] qacc_reg, qacc_next;
    logic [AW-1:0]              mag;
    logic [fng_pkg::QUO_BITS:0] q_round;
    logic [fng_pkg::DIST_W-1:0] d_reg, d_next;
    logic [fng_pkg::DIST_W-1:0] best_reg, best_next;

    // output register
    logic                       ov_reg, ov_next;
    logic [fng_pkg::DIST_W-1:0] odist_reg, odist_next;
    logic                       oempty_reg, oempty_next;
    logic                       ozero_reg, ozero_next;

    // append bookkeeping
    logic [fng_pkg::CNT_W-1:0]    c0, c1, beff;
    logic [fng_pkg::ROW_W-1:0]    o0, o1, wrow;
    logic                         take;

    assign out_valid     = ov_reg;
    assign nn_distance   = odist_reg;
    assign gallery_empty = oempty_reg;
    assign zero_norm     = ozero_reg;

    assign op_ready = state_reg == fng_pkg::B_IDLE;
    assign take     = op_valid && op_ready;

    // effective budget, clamped to 1..depth
    always_comb
    begin
        if (budget == '0)
        begin
            beff = fng_pkg::CNT_W'(1);
        end
        else if (fng_pkg::CNT_W'(budget) > fng_pkg::CNT_W'(fng_pkg::GALLERY_DEPTH))
        begin
            beff = fng_pkg::CNT_W'(fng_pkg::GALLERY_DEPTH);
        end
        else
        begin
            beff = fng_pkg::CNT_W'(budget);
        end
    end

    // ring row and count update for an append
    always_comb
    begin
        c0   = cnt_reg[op.slot];
        o0   = old_reg[op.slot];
        wrow = (c0 < fng_pkg::CNT_W'(fng_pkg::GALLERY_DEPTH))
               ? o0 + c0[fng_pkg::ROW_W-1:0] : o0;
        c1   = c0;
        o1   = o0;
        if (op.full)
        begin
            if (c0 < fng_pkg::CNT_W'(fng_pkg::GALLERY_DEPTH))
            begin
                c1 = c0 + fng_pkg::CNT_W'(1);
            end
            else
            begin
                o1 = o0 + fng_pkg::ROW_W'(1);
            end
        end
        else if (c0 >= fng_pkg::CNT_W'(fng_pkg::GALLERY_DEPTH))
        begin
            o1 = o0 + fng_pkg::ROW_W'(1);
            c1 = c0 - fng_pkg::CNT_W'(1);
        end
    end

    assign gal_we    = take && op.cmd == fng_pkg::CMD_APPEND && op.in_range && op.slot_ok;
    assign qb_we     = take && op.cmd == fng_pkg::CMD_QUERY && op.in_range;
    assign gal_waddr = {op.slot, wrow, op.pos};
    assign issue     = state_reg == fng_pkg::B_SCAN && j_reg < q_len_reg;
    assign gal_raddr = {q_slot_reg, q_old_reg + k_reg[fng_pkg::ROW_W-1:0],
                        j_reg[fng_pkg::POS_W-1:0]};

    // gallery and query memories
    always_ff @(posedge clk)
    begin
        if (gal_we)
        begin
            gal_mem[gal_waddr] <= op.elem;
        end
        gal_rdata <= gal_mem[gal_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (qb_we)
        begin
            qb_mem[op.pos] <= op.elem;
        end
        qb_rdata <= qb_mem[j_reg[fng_pkg::POS_W-1:0]];
    end

    // element products
    assign diff = $signed({gal_rdata[fng_pkg::ELEMENT_WIDTH-1], gal_rdata})
                - $signed({qb_rdata[fng_pkg::ELEMENT_WIDTH-1], qb_rdata});
    assign sq_w = diff * diff;
    assign aa_w = $signed(gal_rdata) * $signed(gal_rdata);
    assign ab_w = $signed(gal_rdata) * $signed(qb_rdata);
    assign bb_w = $signed(qb_rdata) * $signed(qb_rdata);

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_w;
        aa_reg <= aa_w;
        ab_reg <= ab_w;
        bb_reg <= bb_w;
    end

    // square root and divide steps
    assign rem_t   = {rem_reg[fng_pkg::REM_W-3:0], prod_reg[fng_pkg::PROD_W-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign r2      = {r_reg[AW-1:0], 1'b0};
    assign mag     = acc_dot_reg[AW-1] ? AW'(-acc_dot_reg) : acc_dot_reg;
    assign q_round = {1'b0, qacc_reg} + (fng_pkg::QUO_BITS + 1)'(1);

    // next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        old_next    = old_reg;
        mark_next   = mark_reg;
        q_slot_next = q_slot_reg;
        q_len_next  = q_len_reg;
        q_cnt_next  = q_cnt_reg;
        q_old_next  = q_old_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        iter_next   = iter_reg;
        empty_next  = empty_reg;
        zflag_next  = zflag_reg;
        acc_d_next   = acc_d_reg;
        acc_ng_next  = acc_ng_reg;
        acc_nq_next  = acc_nq_reg;
        acc_dot_next = acc_dot_reg;
        prod_next   = prod_reg;
        mcand_next  = mcand_reg;
        mlt_next    = mlt_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        r_next      = r_reg;
        qacc_next   = qacc_reg;
        d_next      = d_reg;
        best_next   = best_reg;
        ov_next     = ov_reg && !out_ready;
        odist_next  = odist_reg;
        oempty_next = oempty_reg;
        ozero_next  = ozero_reg;

        if (issue)
        begin
            j_next = j_reg + fng_pkg::IDX_W'(1);
        end
        if (v2_reg)
        begin
            acc_d_next   = acc_d_reg + AW'(sq_reg);
            acc_ng_next  = acc_ng_reg + AW'(aa_reg);
            acc_nq_next  = acc_nq_reg + AW'(bb_reg);
            acc_dot_next = acc_dot_reg + {{(AW - 2*fng_pkg::ELEMENT_WIDTH){ab_reg[31]}}, ab_reg};
        end

        unique case (state_reg)
            fng_pkg::B_IDLE:
            begin
                if (take)
                begin
                    unique case (op.cmd)
                        fng_pkg::CMD_APPEND:
                        begin
                            if (op.last && op.slot_ok)
                            begin
                                if (c1 > beff)
                                begin
                                    old_next[op.slot] = o1 + fng_pkg::ROW_W'(c1 - beff);
                                    cnt_next[op.slot] = beff;
                                end
                                else
                                begin
                                    old_next[op.slot] = o1;
                                    cnt_next[op.slot] = c1;
                                end
                            end
                        end
                        fng_pkg::CMD_QUERY:
                        begin
                            if (op.last)
                            begin
                                q_slot_next  = op.slot;
                                q_len_next   = op.qlen;
                                q_cnt_next   = c0;
                                q_old_next   = o0;
                                k_next       = '0;
                                j_next       = '0;
                                zflag_next   = 1'b0;
                                best_next    = fng_pkg::DIST_MAX;
                                acc_d_next   = '0;
                                acc_ng_next  = '0;
                                acc_nq_next  = '0;
                                acc_dot_next = '0;
                                empty_next   = !op.slot_ok || c0 == '0;
                                state_next   = (!op.slot_ok || c0 == '0)
                                               ? fng_pkg::B_RESULT : fng_pkg::B_SCAN;
                            end
                        end
                        fng_pkg::CMD_MARK:
                        begin
                            if (op.slot_ok)
                            begin
                                mark_next[op.slot] = 1'b1;
                            end
                        end
                        fng_pkg::CMD_PRUNE:
                        begin
                            for (int i = 0; i < fng_pkg::MAX_TRACKS; i++)
                            begin
                                if (!mark_reg[i])
                                begin
                                    cnt_next[i] = '0;
                                    old_next[i] = '0;
                                end
                            end
                            mark_next = '0;
                        end
                    endcase
                end
            end
            fng_pkg::B_SCAN:
            begin
                if (!issue && !v1_reg && !v2_reg)
                begin
                    state_next = fng_pkg::B_EVAL;
                end
            end
            fng_pkg::B_EVAL:
            begin
                if (metric)
                begin
                    d_next     = fng_pkg::DIST_W'(acc_d_reg);
                    state_next = fng_pkg::B_NEXT;
                end
                else if (acc_ng_reg == '0 || acc_nq_reg == '0)
                begin
                    d_next     = fng_pkg::ONE_Q24;
                    zflag_next = 1'b1;
                    state_next = fng_pkg::B_NEXT;
                end
                else
                begin
                    prod_next  = '0;
                    mcand_next = fng_pkg::PROD_W'(acc_ng_reg);
                    mlt_next   = acc_nq_reg;
                    iter_next  = '0;
                    state_next = fng_pkg::B_MUL;
                end
            end
            fng_pkg::B_MUL:
            begin
                if (mlt_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[fng_pkg::PROD_W-2:0], 1'b0};
                mlt_next   = {1'b0, mlt_reg[AW-1:1]};
                iter_next  = iter_reg + fng_pkg::ITER_W'(1);
                if (iter_reg == fng_pkg::ITER_W'(AW - 1))
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    iter_next  = '0;
                    state_next = fng_pkg::B_SQRT;
                end
            end
            fng_pkg::B_SQRT:
            begin
                if (rem_t >= trial)
                begin
                    rem_next  = rem_t - trial;
                    root_next = {root_reg[fng_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_t;
                    root_next = {root_reg[fng_pkg::ROOT_W-2:0], 1'b0};
                end
                prod_next = {prod_reg[fng_pkg::PROD_W-3:0], 2'b00};
                iter_next = iter_reg + fng_pkg::ITER_W'(1);
                if (iter_reg == fng_pkg::ITER_W'(fng_pkg::ROOT_W - 1))
                begin
                    state_next = fng_pkg::B_QSET;
                end
            end
            fng_pkg::B_QSET:
            begin
                if (mag >= root_reg)
                begin
                    d_next     = acc_dot_reg[AW-1] ? (fng_pkg::ONE_Q24 << 1) : '0;
                    state_next = fng_pkg::B_NEXT;
                end
                else
                begin
                    r_next     = {1'b0, mag};
                    qacc_next  = '0;
                    iter_next  = '0;
                    state_next = fng_pkg::B_DIV;
                end
            end
            fng_pkg::B_DIV:
            begin
                if (r2 >= {1'b0, root_reg})
                begin
                    r_next    = r2 - {1'b0, root_reg};
                    qacc_next = {qacc_reg[fng_pkg::QUO_BITS-2:0], 1'b1};
                end
                else
                begin
                    r_next    = r2;
                    qacc_next = {qacc_reg[fng_pkg::QUO_BITS-2:0], 1'b0};
                end
                iter_next = iter_reg + fng_pkg::ITER_W'(1);
                if (iter_reg == fng_pkg::ITER_W'(fng_pkg::QUO_BITS - 1))
                begin
                    state_next = fng_pkg::B_QEND;
                end
            end
            fng_pkg::B_QEND:
            begin
                if (acc_dot_reg[AW-1])
                begin
                    d_next = fng_pkg::ONE_Q24
                           + fng_pkg::DIST_W'(q_round[fng_pkg::QUO_BITS:1]);
                end
                else
                begin
                    d_next = fng_pkg::ONE_Q24
                           - fng_pkg::DIST_W'(q_round[fng_pkg::QUO_BITS:1]);
                end
                state_next = fng_pkg::B_NEXT;
            end
            fng_pkg::B_NEXT:
            begin
                if (d_reg < best_reg)
                begin
                    best_next = d_reg;
                end
                if (k_reg + fng_pkg::CNT_W'(1) < q_cnt_reg)
                begin
                    k_next       = k_reg + fng_pkg::CNT_W'(1);
                    j_next       = '0;
                    acc_d_next   = '0;
                    acc_ng_next  = '0;
                    acc_nq_next  = '0;
                    acc_dot_next = '0;
                    state_next   = fng_pkg::B_SCAN;
                end
                else
                begin
                    state_next = fng_pkg::B_RESULT;
                end
            end
            fng_pkg::B_RESULT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next     = 1'b1;
                    odist_next  = empty_reg ? '0 : best_reg;
                    oempty_next = empty_reg;
                    ozero_next  = !empty_reg && zflag_reg;
                    state_next  = fng_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = fng_pkg::B_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fng_pkg::B_IDLE;
            for (int i = 0; i < fng_pkg::MAX_TRACKS; i++)
            begin
                cnt_reg[i] <= '0;
                old_reg[i] <= '0;
            end
            mark_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            ov_reg   <= 1'b0;
            j_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            old_reg   <= old_next;
            mark_reg  <= mark_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            ov_reg    <= ov_next;
            j_reg     <= j_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        q_slot_reg  <= q_slot_next;
        q_len_reg   <= q_len_next;
        q_cnt_reg   <= q_cnt_next;
        q_old_reg   <= q_old_next;
        k_reg       <= k_next;
        iter_reg    <= iter_next;
        empty_reg   <= empty_next;
        zflag_reg   <= zflag_next;
        acc_d_reg   <= acc_d_next;
        acc_ng_reg  <= acc_ng_next;
        acc_nq_reg  <= acc_nq_next;
        acc_dot_reg <= acc_dot_next;
        prod_reg    <= prod_next;
        mcand_reg   <= mcand_next;
        mlt_reg     <= mlt_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        r_reg       <= r_next;
        qacc_reg    <= qacc_next;
        d_reg       <= d_next;
        best_reg    <= best_next;
        odist_reg   <= odist_next;
        oempty_reg  <= oempty_next;
        ozero_reg   <= ozero_next;
    end

endmodule
